/* rtl/core/lru_key_value_cache_top_assert.svh */
// Assertion macros used by the checker of the cache.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LKVC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define LKVC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 31;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lkvc_state_t;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkvc_kv_t;

  // Recency update command from the sequencer to the rank file.
  typedef struct packed {
    logic promote;     // make the target slot the most recent
    logic age_all;     // age every other valid slot, not just the younger ones
    logic mark_valid;  // the target slot becomes valid
  } lkvc_rank_cmd_t;

endpackage

/* rtl/core/lkvc_kv_mem.sv */
module lkvc_kv_mem #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output lkvc_pkg::lkvc_kv_t  rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  lkvc_pkg::lkvc_kv_t  wr_data
);

  lkvc_pkg::lkvc_kv_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lkvc_rank_file.sv */
module lkvc_rank_file #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [IDX_W-1:0]         look_idx,
  output logic                     look_valid,
  output logic [IDX_W-1:0]         look_rank,
  input  lkvc_pkg::lkvc_rank_cmd_t cmd,
  input  logic [IDX_W-1:0]         target,
  input  logic [IDX_W-1:0]         limit
);

  logic [IDX_W-1:0] rank  [ENTRIES];
  logic             valid [ENTRIES];

  assign look_valid = valid[look_idx];
  assign look_rank  = rank[look_idx];

  // Each slot ages on its own: one increment per slot, all in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.promote) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == target) begin
          rank[i] <= '0;
        end else if (valid[i] && (cmd.age_all || (rank[i] < limit))) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (cmd.promote && cmd.mark_valid) begin
      valid[target] <= 1'b1;
    end
  end

endmodule

/* rtl/core/lru_key_value_cache_top.sv */
// Channel  | Ports                                   | Handshake
// request  | operation, lookup_key, store_value      | start high, busy low
// result   | found, read_value                       | done, one cycle, no back-pressure
// config   | cfg_wdata (capacity_in_use)             | cfg_we, taken at once
//
// From acceptance to done, each request makes one pass over the key/value
// memory, one entry per cycle, each entry compared in the cycle after its
// read, then an update step that writes back and ages ranks.
// busy stays high from the cycle after acceptance up to and including the done cycle.
// Reset clears the valid bits, the fill count and sets the capacity to 16;
// keys, values and ranks hold garbage until written, which is never seen.
// The result cannot be stalled; the next request may start right after done.
module lru_key_value_cache_top #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
  input  logic        [lkvc_pkg::VAL_W-1:0] store_value,
  output logic                              done,
  output logic                              found,
  output logic        [lkvc_pkg::VAL_W-1:0] read_value,
  input  logic                              cfg_we,
  input  logic        [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  lkvc_pkg::lkvc_state_t state, state_next;

  // Request held for the whole operation.
  logic                       req_op;
  logic [lkvc_pkg::KEY_W-1:0] req_key;
  logic [lkvc_pkg::VAL_W-1:0] req_val;

  logic [lkvc_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]           used;
  logic [CNT_W-1:0]           scan_cnt;

  // Scan results.
  logic                       hit;
  logic [IDX_W-1:0]           hit_idx;
  logic [IDX_W-1:0]           hit_rank;
  logic [lkvc_pkg::VAL_W-1:0] hit_val;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;
  logic                       old_found;
  logic [IDX_W-1:0]           old_idx;
  logic [IDX_W-1:0]           old_rank;

  logic                      accept;
  logic                      rd_en;
  logic [IDX_W-1:0]          cmp_idx;
  logic                      cmp_live;
  lkvc_pkg::lkvc_kv_t        rd_data;
  lkvc_pkg::lkvc_kv_t        wr_data;
  logic                      wr_en;
  logic [IDX_W-1:0]          target;
  logic                      ent_valid;
  logic [IDX_W-1:0]          ent_rank;
  logic                      room;
  logic                      do_insert;
  logic                      do_evict;
  lkvc_pkg::lkvc_rank_cmd_t  cmd;

  assign accept   = start && (state == lkvc_pkg::ST_IDLE);
  assign rd_en    = (state == lkvc_pkg::ST_SCAN) && (scan_cnt < CNT_W'(ENTRIES));
  assign cmp_live = (state == lkvc_pkg::ST_SCAN) && (scan_cnt != '0);
  assign cmp_idx  = IDX_W'(scan_cnt - 1'b1);

  lkvc_kv_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_kv_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (target),
    .wr_data (wr_data)
  );

  lkvc_rank_file #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_rank_file (
    .clk        (clk),
    .rst        (rst),
    .look_idx   (cmp_idx),
    .look_valid (ent_valid),
    .look_rank  (ent_rank),
    .cmd        (cmd),
    .target     (target),
    .limit      (hit_rank)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (scan_cnt == CNT_W'(ENTRIES)) begin
          state_next = lkvc_pkg::ST_UPDATE;
        end
      end
      lkvc_pkg::ST_UPDATE: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capacity 0 acts as 1; anything above ENTRIES is caught by the free-slot
  // search, since a free slot exists only while fewer than ENTRIES are held.
  always_comb begin
    if (capacity == '0) begin
      room = free_found && (used == '0);
    end else begin
      room = free_found && (CMP_W'(used) < CMP_W'(capacity));
    end
  end

  // Write-back decisions, used only in the update cycle.
  always_comb begin
    do_insert = (req_op == lkvc_pkg::OP_SET) && !hit && room;
    do_evict  = (req_op == lkvc_pkg::OP_SET) && !hit && !room && old_found;
    if (hit) begin
      target = hit_idx;
    end else if (do_insert) begin
      target = free_idx;
    end else begin
      target = old_idx;
    end
  end

  // Outputs of the state machine.
  always_comb begin
    busy           = (state != lkvc_pkg::ST_IDLE);
    done           = 1'b0;
    wr_en          = 1'b0;
    cmd.promote    = 1'b0;
    cmd.age_all    = !hit;
    cmd.mark_valid = do_insert;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
      end
      lkvc_pkg::ST_SCAN: begin
      end
      lkvc_pkg::ST_UPDATE: begin
        done        = 1'b1;
        wr_en       = (hit && (req_op == lkvc_pkg::OP_SET)) || do_insert || do_evict;
        cmd.promote = hit || do_insert || do_evict;
      end
      default: begin
      end
    endcase
  end

  assign wr_data.key   = req_key;
  assign wr_data.value = req_val;
  assign found         = hit;
  assign read_value    = (hit && (req_op == lkvc_pkg::OP_GET)) ? hit_val : '0;

  // Latch the request on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= operation;
      req_key <= $unsigned(lookup_key);
      req_val <= store_value;
    end
  end

  // Capacity register: written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Fill count: advance on each insert into a free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if ((state == lkvc_pkg::ST_UPDATE) && do_insert) begin
      used <= used + 1'b1;
    end
  end

  // Scan: walk the memory, compare each entry in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (accept) begin
      scan_cnt   <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (state == lkvc_pkg::ST_SCAN) begin
      if (scan_cnt != CNT_W'(ENTRIES)) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmp_live) begin
        if (ent_valid && !hit && (rd_data.key == req_key)) begin
          hit <= 1'b1;
        end
        if (!ent_valid && !free_found) begin
          free_found <= 1'b1;
        end
        if (ent_valid && (!old_found || (ent_rank > old_rank))) begin
          old_found <= 1'b1;
        end
      end
    end
  end

  // Scan payload: indices, ranks and value of the entries found.
  always_ff @(posedge clk) begin
    if (cmp_live) begin
      if (ent_valid && !hit && (rd_data.key == req_key)) begin
        hit_idx  <= cmp_idx;
        hit_rank <= ent_rank;
        hit_val  <= rd_data.value;
      end
      if (!ent_valid && !free_found) begin
        free_idx <= cmp_idx;
      end
      if (ent_valid && (!old_found || (ent_rank > old_rank))) begin
        old_idx  <= cmp_idx;
        old_rank <= ent_rank;
      end
    end
  end

endmodule

/* rtl/core/lkvc_checker.sv */
`include "lru_key_value_cache_top_assert.svh"

module lkvc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       found,
  input logic [lkvc_pkg::VAL_W-1:0] read_value
);

  // An accepted request keeps the block busy in the next cycle.
  `LKVC_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")

  // A result only follows a cycle in which a request was in flight.
  `LKVC_ASSERT_IMP(a_done_after_busy, clk, rst, done, busy && $past(busy), "done without request")

  // The block is free again right after a result.
  `LKVC_ASSERT_NXT(a_done_frees, clk, rst, done, !busy && !done, "busy after done")

  // A miss never carries a value.
  `LKVC_ASSERT_IMP(a_miss_zero, clk, rst, done && !found, read_value == '0, "miss with value")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .found      (found),
  .read_value (read_value)
);
